// File: sv/blt_pkg.sv
// ----------------------------------------------------------------------------
// blt_pkg
// Shared codes and defaults for the bounded list table core.
// ----------------------------------------------------------------------------
package blt_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int WIDTH_DEFAULT = 32;

	localparam logic [4:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_READ   = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_DELETE = 2'd3
	} blt_action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_BAD_INDEX = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} blt_status_t;

endpackage

// File: sv/bounded_list_table_core.sv
// ----------------------------------------------------------------------------
// bounded_list_table_core
// Packed list of words in one synchronous memory: append, read at index,
// linear search and delete with shift-down.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_valid / cfg_ready  cfg_data (capacity in use)
//  in        in         in_valid / in_stall    action, value, index
//  out       out        out_valid / out_stall  status, data, position, count
//
// one item at a time; the scan reads one entry per cycle from the single
// memory read port and the shift of a delete carries on from the matching
// slot.
// the result sits in an output register, so the next item is taken while
// a result is still stalled; its own result then waits in finish until the
// register is free.
// reset clears the entry count; slots at or above the count read as zero.
// config writes are taken only while no item is in progress.
module bounded_list_table_core
	import blt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int WIDTH = WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [31:0] value,
	input  logic [3:0]  index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] data,
	output logic [3:0]  position,
	output logic [4:0]  count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDWAIT,
		ST_SCAN,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	state_t            state_q;
	blt_action_t       act_q;
	logic [WIDTH-1:0]  word_q;
	logic [3:0]        idx_q;
	logic [AW-1:0]     ptr_q;
	logic [CW-1:0]     count_q;
	logic [4:0]        cap_q;
	logic [CW-1:0]     cap_eff;
	blt_status_t       res_status_q;
	logic [31:0]       res_data_q;
	logic [3:0]        res_pos_q;
	logic              out_valid_q;
	logic [1:0]        out_status_q;
	logic [31:0]       out_data_q;
	logic [3:0]        out_pos_q;
	logic [4:0]        out_count_q;

	logic [WIDTH-1:0]  mem [DEPTH];
	logic [WIDTH-1:0]  rdata_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WIDTH-1:0]  wr_data;
	logic              take_in;
	logic              has_room;
	logic              next_in_list;

	// zero acts as one, anything above the built depth as the depth
	always_comb begin
		if (cap_q == 5'd0)
			cap_eff = CW'(1);
		else if (int'(cap_q) > DEPTH)
			cap_eff = CW'(DEPTH);
		else
			cap_eff = CW'(cap_q);
	end

	assign take_in      = in_valid && (state_q == ST_IDLE);
	assign has_room     = (count_q < cap_eff);
	assign next_in_list = (int'(ptr_q) + 1 < int'(count_q));

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign data      = out_data_q;
	assign position  = out_pos_q;
	assign count     = out_count_q;

	// the scan and the shift always fetch the entry after the current one
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = (action == ACT_READ) ? AW'(index) : '0;
			ST_SCAN,
			ST_SHIFT: rd_addr = ptr_q + 1'b1;
			default:  rd_addr = '0;
		endcase
	end

	// shift writes the entry just read one slot down
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(count_q);
		wr_data = WIDTH'(value);
		if (take_in && (action == ACT_APPEND) && has_room) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SHIFT) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q - 1'b1;
			wr_data = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			cap_q        <= CAP_RESET;
			out_valid_q  <= 1'b0;
			act_q        <= ACT_APPEND;
			word_q       <= '0;
			idx_q        <= '0;
			ptr_q        <= '0;
			res_status_q <= STAT_OK;
			res_data_q   <= '0;
			res_pos_q    <= '0;
			out_status_q <= '0;
			out_data_q   <= '0;
			out_pos_q    <= '0;
			out_count_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						act_q        <= blt_action_t'(action);
						word_q       <= WIDTH'(value);
						idx_q        <= index;
						ptr_q        <= '0;
						res_status_q <= STAT_OK;
						res_data_q   <= '0;
						res_pos_q    <= '0;
						case (action)
							ACT_APPEND: begin
								if (has_room)
									count_q <= count_q + 1'b1;
								else
									res_status_q <= STAT_OVERFLOW;
								state_q <= ST_FINISH;
							end
							ACT_READ: begin
								if (int'(index) >= int'(cap_eff)) begin
									res_status_q <= STAT_BAD_INDEX;
									state_q      <= ST_FINISH;
								end else begin
									state_q <= ST_RDWAIT;
								end
							end
							default: begin
								if (count_q == '0) begin
									res_status_q <= STAT_NOT_FOUND;
									state_q      <= ST_FINISH;
								end else begin
									state_q <= ST_SCAN;
								end
							end
						endcase
					end
				end
				ST_RDWAIT: begin
					// slots past the count hold stale words and read as zero
					if (int'(idx_q) < int'(count_q))
						res_data_q <= 32'(rdata_q);
					state_q <= ST_FINISH;
				end
				ST_SCAN: begin
					if (rdata_q == word_q) begin
						res_pos_q <= 4'(ptr_q);
						if (act_q == ACT_SEARCH) begin
							state_q <= ST_FINISH;
						end else if (next_in_list) begin
							ptr_q   <= ptr_q + 1'b1;
							state_q <= ST_SHIFT;
						end else begin
							count_q <= count_q - 1'b1;
							state_q <= ST_FINISH;
						end
					end else if (next_in_list) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						res_status_q <= STAT_NOT_FOUND;
						state_q      <= ST_FINISH;
					end
				end
				ST_SHIFT: begin
					if (next_in_list) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_data_q   <= res_data_q;
						out_pos_q    <= res_pos_q;
						out_count_q  <= 5'(count_q);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("entry count beyond depth");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result loaded outside finish");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(take_in && (action == ACT_APPEND) && has_room)
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not grow the list");

	a_shift_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> ((ptr_q != '0) && (int'(ptr_q) < int'(count_q))))
		else $error("shift pointer outside stored entries");

endmodule
